### rtl/wide_multiply_divide_top_defines.svh
// Assertion helpers for the wide multiply/divide block.
`ifndef WIDE_MULTIPLY_DIVIDE_TOP_DEFINES_SVH
`define WIDE_MULTIPLY_DIVIDE_TOP_DEFINES_SVH

// Checked only outside reset.
`define WMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked also during reset.
`define WMD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/wmd_pkg.sv
// ----------------------------------------------------------------------------
// wmd_pkg
// Shared widths and the record carried down the divider pipeline.
// ----------------------------------------------------------------------------
package wmd_pkg;

  localparam int WORD_W    = 64;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int HALF_W    = WORD_W / 2;
  localparam int DIV_STEPS = PROD_W;

  typedef struct packed {
    logic              valid;
    logic              dz;     // divisor zero: word is rotated, not divided
    logic [WORD_W-1:0] d;
    logic [WORD_W-1:0] rem;
    logic [PROD_W-1:0] n;      // dividend bits out at top, quotient bits in at bottom
  } div_stage_t;

endpackage

### rtl/wmd_mul.sv
// ----------------------------------------------------------------------------
// wmd_mul
// Two-stage 64x64 multiply: 32x32 partial products, then the column sums.
// ----------------------------------------------------------------------------
module wmd_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [wmd_pkg::WORD_W-1:0] a,
  input  logic [wmd_pkg::WORD_W-1:0] b,
  input  logic [wmd_pkg::WORD_W-1:0] d,
  output wmd_pkg::div_stage_t        out_stage
);
  import wmd_pkg::*;

  logic              v1_r;
  logic [WORD_W-1:0] p00_r, p01_r, p10_r, p11_r, d1_r;
  div_stage_t        st_r, st_nxt;
  logic [HALF_W+1:0] mid;
  logic [WORD_W-1:0] lo, hi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r <= WORD_W'(a[HALF_W-1:0])      * WORD_W'(b[HALF_W-1:0]);
      p01_r <= WORD_W'(a[HALF_W-1:0])      * WORD_W'(b[WORD_W-1:HALF_W]);
      p10_r <= WORD_W'(a[WORD_W-1:HALF_W]) * WORD_W'(b[HALF_W-1:0]);
      p11_r <= WORD_W'(a[WORD_W-1:HALF_W]) * WORD_W'(b[WORD_W-1:HALF_W]);
      d1_r  <= d;
    end
  end

  always_comb begin
    mid = (HALF_W+2)'(p00_r[WORD_W-1:HALF_W]) + (HALF_W+2)'(p01_r[HALF_W-1:0])
        + (HALF_W+2)'(p10_r[HALF_W-1:0]);
    lo  = {mid[HALF_W-1:0], p00_r[HALF_W-1:0]};
    hi  = p11_r + WORD_W'(p01_r[WORD_W-1:HALF_W]) + WORD_W'(p10_r[WORD_W-1:HALF_W])
        + WORD_W'(mid[HALF_W+1:HALF_W]);
    st_nxt.valid = v1_r;
    st_nxt.dz    = (d1_r == '0);
    st_nxt.d     = d1_r;
    st_nxt.rem   = '0;
    st_nxt.n     = {hi, lo};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else if (en) begin
      st_r.valid <= st_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r.dz  <= st_nxt.dz;
      st_r.d   <= st_nxt.d;
      st_r.rem <= st_nxt.rem;
      st_r.n   <= st_nxt.n;
    end
  end

  assign out_stage = st_r;

endmodule

### rtl/wmd_div_step.sv
// ----------------------------------------------------------------------------
// wmd_div_step
// One registered restoring-division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module wmd_div_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  wmd_pkg::div_stage_t in_stage,
  output wmd_pkg::div_stage_t out_stage
);
  import wmd_pkg::*;

  div_stage_t        st_r, st_nxt;
  logic [WORD_W:0]   rem2;
  logic [WORD_W:0]   diff;
  logic              ge;

  always_comb begin
    rem2   = {in_stage.rem, in_stage.n[PROD_W-1]};
    ge     = (rem2 >= {1'b0, in_stage.d});
    diff   = rem2 - {1'b0, in_stage.d};
    st_nxt = in_stage;
    st_nxt.rem = ge ? diff[WORD_W-1:0] : rem2[WORD_W-1:0];
    // zero divisor: rotate so the product comes back intact after all steps
    st_nxt.n   = {in_stage.n[PROD_W-2:0], in_stage.dz ? in_stage.n[PROD_W-1] : ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else if (en) begin
      st_r.valid <= st_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r.dz  <= st_nxt.dz;
      st_r.d   <= st_nxt.d;
      st_r.rem <= st_nxt.rem;
      st_r.n   <= st_nxt.n;
    end
  end

  assign out_stage = st_r;

endmodule

### rtl/wide_multiply_divide_top.sv
// Stages: 2 multiply, 128 divide (one quotient bit each), 1 output register.
// Throughput: one beat per cycle unless the output stalls; the divider sets depth.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// wide_multiply_divide_top
// floor(value*multiplier/divisor) from an exact 128-bit product, low 64 bits.
// ----------------------------------------------------------------------------
module wide_multiply_divide_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [wmd_pkg::WORD_W-1:0] in_value,
  input  logic [wmd_pkg::WORD_W-1:0] in_multiplier,
  input  logic [wmd_pkg::WORD_W-1:0] in_divisor,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [wmd_pkg::WORD_W-1:0] out_quotient,
  output logic                       out_divide_by_zero,
  output logic                       out_overflow
);
  import wmd_pkg::*;

  logic       adv;
  div_stage_t chain [DIV_STEPS+1];
  div_stage_t last;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  wmd_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_valid),
    .a         (in_value),
    .b         (in_multiplier),
    .d         (in_divisor),
    .out_stage (chain[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    wmd_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_stage  (chain[i]),
      .out_stage (chain[i+1])
    );
  end

  assign last = chain[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_quotient       <= last.n[WORD_W-1:0];
      out_divide_by_zero <= last.dz;
      out_overflow       <= (last.n[PROD_W-1:WORD_W] != '0);
    end
  end

endmodule

### rtl/wmd_checker.sv
// ----------------------------------------------------------------------------
// wmd_checker
// Port-level checks on the wide multiply/divide top level.
// ----------------------------------------------------------------------------
`include "wide_multiply_divide_top_defines.svh"

module wmd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [wmd_pkg::WORD_W-1:0] out_quotient,
  input logic                       out_divide_by_zero,
  input logic                       out_overflow
);
  import wmd_pkg::*;

  // a stalled result beat holds
  `WMD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_quotient) && $stable(out_divide_by_zero) && $stable(out_overflow), "result beat changed while stalled")

  // input side flows whenever the output slot is free
  `WMD_ASSERT(a_ready_flow, in_ready == (!out_valid || out_ready), "input ready not tied to output slot")

  // no result right after reset
  `WMD_ASSERT_RST(a_reset_clear, !$past(rst_n) |-> !out_valid, "result valid after reset")

endmodule

bind wide_multiply_divide_top wmd_checker u_wmd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_quotient       (out_quotient),
  .out_divide_by_zero (out_divide_by_zero),
  .out_overflow       (out_overflow)
);

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Scoreboard bench for wide_multiply_divide_top: directed corner rows plus
// random operands, checked against typed-in results or an exact 128-bit predictor.
// ----------------------------------------------------------------------------
module tb;
  import wmd_pkg::*;

  localparam int LATENCY   = 131;
  localparam int N_RANDOM  = 500;
  localparam int CYCLE_MAX = 400000;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [PROD_W-1:0] wide_t;

  typedef struct {
    word_t quotient;
    logic  dz;
    logic  ovf;
  } scaled_t;

  typedef struct {
    word_t   value;
    word_t   mul;
    word_t   div;
    logic    known;   // expected result typed in below
    scaled_t res;
  } row_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic  clk, rst_n;
  logic  in_valid, in_ready, out_valid, out_ready;
  word_t in_value, in_multiplier, in_divisor, out_quotient;
  logic  out_divide_by_zero, out_overflow;

  scaled_t    pending_q[$];
  int         errors, cycles, n_checked, n_dz, n_ovf;
  idle_mode_e mode;
  row_t       rows[$];

  wide_multiply_divide_top u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_value, .in_multiplier, .in_divisor,
    .out_valid, .out_ready, .out_quotient, .out_divide_by_zero, .out_overflow
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic scaled_t scale(word_t v, word_t m, word_t d);
    scaled_t r;
    wide_t   prod, quo;
    prod = wide_t'(v) * wide_t'(m);
    if (d == '0) begin
      r.quotient = prod[WORD_W-1:0];
      r.dz       = 1'b1;
      r.ovf      = |prod[PROD_W-1:WORD_W];
    end else begin
      quo        = prod / wide_t'(d);
      r.quotient = quo[WORD_W-1:0];
      r.dz       = 1'b0;
      r.ovf      = |quo[PROD_W-1:WORD_W];
    end
    return r;
  endfunction

  task automatic report(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] exp);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, exp);
  endtask

  function automatic word_t rand_word();
    word_t w;
    w = {$urandom(), $urandom()};
    case ($urandom_range(0, 7))
      0: w = '0;
      1: w = '1;
      2: w = word_t'(1) << $urandom_range(0, 63);
      3: w = w >> $urandom_range(1, 63);
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic stall();
    case (mode)
      IDLE_SEND, IDLE_RECV: return $urandom_range(0, 99) < 65;
      IDLE_BOTH:            return $urandom_range(0, 99) < 13;
      default:              return 1'b0;
    endcase
  endfunction

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (mode == IDLE_RECV || mode == IDLE_BOTH) ? !stall() : 1'b1;
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          report("unexpected beat", out_quotient, '0);
        end else begin
          scaled_t e;
          e = pending_q.pop_front();
          n_checked++;
          if (out_quotient !== e.quotient) report("quotient", out_quotient, e.quotient);
          if (out_divide_by_zero !== e.dz)
            report("divide_by_zero", out_divide_by_zero, e.dz);
          if (out_overflow !== e.ovf) report("overflow", out_overflow, e.ovf);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_MAX) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb NOT OK");
      $finish;
    end
  end

  // valid stays up between back-to-back beats; it drops only for sender idle cycles
  task automatic send(word_t v, word_t m, word_t d, scaled_t exp);
    if (mode == IDLE_SEND || mode == IDLE_BOTH)
      while (stall()) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid      <= 1'b1;
    in_value      <= v;
    in_multiplier <= m;
    in_divisor    <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_q.push_back(exp);
    n_dz  += exp.dz;
    n_ovf += exp.ovf;
  endtask

  function automatic row_t mk(word_t v, word_t m, word_t d, logic k = 0,
                              word_t q = 0, logic z = 0, logic o = 0);
    row_t r;
    r.value = v; r.mul = m; r.div = d; r.known = k;
    r.res.quotient = q; r.res.dz = z; r.res.ovf = o;
    return r;
  endfunction

  initial begin
    word_t   max;
    scaled_t e;
    max = '1;
    errors = 0; cycles = 0; n_checked = 0; n_dz = 0; n_ovf = 0;
    mode = IDLE_NONE;
    rst_n = 1'b0; in_valid = 1'b0;
    in_value = '0; in_multiplier = '0; in_divisor = '0;
    rows.push_back(mk(0, 0, 0, 1, 0, 1, 0));
    rows.push_back(mk(0, max, 1, 1, 0, 0, 0));
    rows.push_back(mk(max, 1, 1, 1, max, 0, 0));
    rows.push_back(mk(max, max, max, 1, max, 0, 0));
    rows.push_back(mk(max, max, 0, 1, 64'h1, 1, 1));     // product wraps
    rows.push_back(mk(max, max, 1, 1, 64'h1, 0, 1));     // quotient too wide
    rows.push_back(mk(7, 3, 0, 1, 21, 1, 0));
    rows.push_back(mk(7, 3, 2, 1, 10, 0, 0));            // floor
    rows.push_back(mk(1, 1, max, 1, 0, 0, 0));
    rows.push_back(mk(64'h1 << 63, 2, 0, 1, 0, 1, 1));
    rows.push_back(mk(64'h1 << 63, 2, 2, 1, 64'h1 << 63, 0, 0));
    rows.push_back(mk(max, max, 64'h1 << 63));
    rows.push_back(mk(max, 2, 3));
    rows.push_back(mk(64'h1_0000_0000, 64'h1_0000_0000, 64'h2_0000_0000));
    rows.push_back(mk(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'hFFFF));
    rows.push_back(mk(64'h1234_5678_9ABC_DEF0, 1000, 999));
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      e = rows[i].known ? rows[i].res : scale(rows[i].value, rows[i].mul, rows[i].div);
      send(rows[i].value, rows[i].mul, rows[i].div, e);
    end

    for (int p = 0; p < 4; p++) begin
      mode = idle_mode_e'(p);
      for (int i = 0; i < N_RANDOM / 4; i++) begin
        word_t v, m, d;
        v = rand_word(); m = rand_word(); d = rand_word();
        // keep most quotients in range: divisor at least the product's upper half
        if ($urandom_range(0, 1) && d != 0)
          d = d | word_t'((wide_t'(v) * wide_t'(m)) >> WORD_W);
        send(v, m, d, scale(v, m, d));
      end
    end
    in_valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("checked %0d beats (%0d divide-by-zero, %0d overflow) over 4 idle patterns",
             n_checked, n_dz, n_ovf);
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule
